@@ rtl/core/cmts_pkg.sv @@
// Shared types, constants and keyword tables for the C-minus token scanner.
`default_nettype none

package cmts_pkg;

  localparam int LINE_BITS = 16;
  localparam int LEN_BITS  = 8;
  localparam int KW_COUNT  = 8;

  // Token kinds
  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_ERR    = 5'd1;
  localparam logic [4:0] K_KW0    = 5'd2;
  localparam logic [4:0] K_ID     = 5'd10;
  localparam logic [4:0] K_NUM    = 5'd11;
  localparam logic [4:0] K_ASSIGN = 5'd12;
  localparam logic [4:0] K_EQ     = 5'd13;
  localparam logic [4:0] K_NE     = 5'd14;
  localparam logic [4:0] K_LT     = 5'd15;
  localparam logic [4:0] K_GT     = 5'd16;
  localparam logic [4:0] K_LE     = 5'd17;
  localparam logic [4:0] K_GE     = 5'd18;
  localparam logic [4:0] K_PLUS   = 5'd19;
  localparam logic [4:0] K_MINUS  = 5'd20;
  localparam logic [4:0] K_TIMES  = 5'd21;
  localparam logic [4:0] K_DIV    = 5'd22;
  localparam logic [4:0] K_LPAREN = 5'd23;
  localparam logic [4:0] K_RPAREN = 5'd24;
  localparam logic [4:0] K_SEMI   = 5'd25;
  localparam logic [4:0] K_COLON  = 5'd26;
  localparam logic [4:0] K_COMMA  = 5'd27;
  localparam logic [4:0] K_LBRACK = 5'd28;
  localparam logic [4:0] K_RBRACK = 5'd29;
  localparam logic [4:0] K_LBRACE = 5'd30;
  localparam logic [4:0] K_RBRACE = 5'd31;

  typedef enum logic [11:0] {
    ST_START   = 12'b0000_0000_0001,
    ST_NUM     = 12'b0000_0000_0010,
    ST_FRAC    = 12'b0000_0000_0100,
    ST_ID      = 12'b0000_0000_1000,
    ST_SLASH   = 12'b0000_0001_0000,
    ST_LINECMT = 12'b0000_0010_0000,
    ST_BLOCK   = 12'b0000_0100_0000,
    ST_STAR    = 12'b0000_1000_0000,
    ST_LT      = 12'b0001_0000_0000,
    ST_EQ      = 12'b0010_0000_0000,
    ST_GT      = 12'b0100_0000_0000,
    ST_BANG    = 12'b1000_0000_0000
  } scan_state_t;

  typedef struct packed {
    scan_state_t         state;
    logic [LINE_BITS-1:0] line;
    logic [LEN_BITS-1:0]  len;
    logic [KW_COUNT-1:0]  alive;
  } scan_ctx_t;

  typedef struct packed {
    logic [4:0]           kind;
    logic [LINE_BITS-1:0] line;
    logic [LEN_BITS-1:0]  len;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic                emit;
    logic                again;
    logic [4:0]          kind;
    logic [LEN_BITS-1:0] len;
  } step_res_t;

  // Reserved words in kind order: int double void if else while for return
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd6, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6
  };

  localparam logic [7:0] KW_CH [KW_COUNT][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };

endpackage

`default_nettype wire

@@ rtl/core/cmts_if.sv @@
// Valid/ready channel interfaces for scanner input characters and tokens.
`default_nettype none

interface cmts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface cmts_out_if;
  logic                           valid;
  logic                           ready;
  logic [4:0]                     token_kind;
  logic [cmts_pkg::LINE_BITS-1:0] line_number;
  logic [cmts_pkg::LEN_BITS-1:0]  lexeme_length;
  logic                           last_of_run;

  modport source (output valid, token_kind, line_number, lexeme_length, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, line_number, lexeme_length, last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/c_minus_token_scanner_top.sv @@
// Top level of the C-minus token scanner: input register, two automaton passes, token queue.
// A transferred character waits in the input register until the token queue has room for
//   two tokens; its tokens are then written to the queue, whose head is offered on the output.
// Throughput: one character per cycle while each yields at most one token and the sink
//   keeps up; the four-entry token queue absorbs a character that yields two tokens.
// Reset (synchronous, rst_n low): start state, line count zero, queue empty.
`default_nettype none

module c_minus_token_scanner_top (
  input  logic       clk,
  input  logic       rst_n,
  cmts_in_if.sink    in_chan,
  cmts_out_if.source out_chan
);
  import cmts_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Input register
  logic       item_v_r, item_v_nxt;
  logic [7:0] item_char_r;
  logic       item_eof_r;
  logic       in_xfer;
  logic       proc;

  // Scanner context
  scan_ctx_t ctx_r, ctx_nxt;
  scan_ctx_t ctx_p1, ctx_p2;
  step_res_t res_p1, res_p2;
  logic      use_p2;

  // Token queue
  token_t           queue_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;
  logic [1:0]       n_push;
  logic             pop;
  token_t           tok_a, tok_b;

  // Take a new character whenever the held one moves on this cycle; process the held
  // character only when the queue has room for the two tokens it might produce.
  assign proc       = item_v_r && (cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));
  assign in_chan.ready = !item_v_r || proc;
  assign in_xfer    = in_chan.valid && in_chan.ready;
  assign item_v_nxt = in_xfer || (item_v_r && !proc);

  // First pass from the held context
  cmts_step u_pass1 (
    .ctx_i  (ctx_r),
    .char_i (item_char_r),
    .eof_i  (item_eof_r),
    .ctx_o  (ctx_p1),
    .res_o  (res_p1)
  );

  // Second pass rescans the terminating character from the start state
  cmts_step u_pass2 (
    .ctx_i  (ctx_p1),
    .char_i (item_char_r),
    .eof_i  (item_eof_r),
    .ctx_o  (ctx_p2),
    .res_o  (res_p2)
  );

  assign use_p2  = res_p1.emit && res_p1.again;
  assign ctx_nxt = use_p2 ? ctx_p2 : ctx_p1;

  // Build the tokens for this character; tok_b is only used when both passes emit
  always_comb begin
    tok_a.kind = res_p1.emit ? res_p1.kind : res_p2.kind;
    tok_a.line = res_p1.emit ? ctx_p1.line : ctx_p2.line;
    tok_a.len  = res_p1.emit ? res_p1.len  : res_p2.len;
    tok_a.last = !(use_p2 && res_p2.emit);
    tok_b.kind = res_p2.kind;
    tok_b.line = ctx_p2.line;
    tok_b.len  = res_p2.len;
    tok_b.last = 1'b1;
    if (!proc) begin
      n_push = 2'd0;
    end else if (res_p1.emit) begin
      n_push = (use_p2 && res_p2.emit) ? 2'd2 : 2'd1;
    end else begin
      n_push = 2'd0;
    end
  end

  // Output side: head of the queue
  assign out_chan.valid         = (cnt_r != '0);
  assign out_chan.token_kind    = queue_r[rd_ptr_r].kind;
  assign out_chan.line_number   = queue_r[rd_ptr_r].line;
  assign out_chan.lexeme_length = queue_r[rd_ptr_r].len;
  assign out_chan.last_of_run   = queue_r[rd_ptr_r].last;
  assign pop = out_chan.valid && out_chan.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(n_push);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + (Q_AW+1)'(n_push) - (Q_AW+1)'(pop);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      ctx_r.state <= ST_START;
      ctx_r.line  <= '0;
      ctx_r.len   <= '0;
      ctx_r.alive <= '1;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      item_v_r <= item_v_nxt;
      if (proc) ctx_r <= ctx_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload: hold the character until processed, write tokens in order
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_char_r <= in_chan.char_code;
      item_eof_r  <= in_chan.end_of_input;
    end
    if (n_push != 2'd0) queue_r[wr_ptr_r] <= tok_a;
    if (n_push == 2'd2) queue_r[wr_ptr_r + 1'b1] <= tok_b;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("token queue over-full");

  a_eof_token: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_eof_r |-> n_push != 2'd0)
    else $error("end of input produced no token");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_eof_r |=> ctx_r.state == ST_START && ctx_r.len == '0)
    else $error("scanner not back at start after end of input");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |=> out_chan.valid)
    else $error("queued token not offered");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cmts_step.sv @@
// One combinational pass of the lexical automaton over a single character.
`default_nettype none

module cmts_step (
  input  cmts_pkg::scan_ctx_t ctx_i,
  input  logic [7:0]          char_i,
  input  logic                eof_i,
  output cmts_pkg::scan_ctx_t ctx_o,
  output cmts_pkg::step_res_t res_o
);
  import cmts_pkg::*;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;

  logic                 keep;
  logic                 is_digit;
  logic                 is_letter;
  logic                 found;
  logic [4:0]           kind;
  logic                 emit;
  logic                 again;
  scan_state_t          st_nxt;
  logic [LINE_BITS-1:0] line_nxt;
  logic [LEN_BITS-1:0]  len_nxt;
  logic [KW_COUNT-1:0]  alive_nxt;

  always_comb begin
    is_digit  = char_i inside {["0":"9"]};
    is_letter = (char_i inside {["a":"z"], ["A":"Z"]}) || (char_i == "_");
  end

  always_comb begin
    keep     = 1'b0;
    emit     = 1'b0;
    again    = 1'b0;
    kind     = K_ERR;
    st_nxt   = ctx_i.state;
    line_nxt = ctx_i.line;

    case (ctx_i.state)
      ST_START: begin
        if (eof_i) begin
          emit = 1'b1;
          kind = K_EOF;
        end else if (is_digit) begin
          st_nxt = ST_NUM;
          keep   = 1'b1;
        end else if (is_letter) begin
          st_nxt = ST_ID;
          keep   = 1'b1;
        end else if (char_i == "/") begin
          st_nxt = ST_SLASH;
        end else if (char_i == " " || char_i == CH_TAB) begin
          st_nxt = ST_START;
        end else if (char_i == CH_NL) begin
          if (ctx_i.line != '1) line_nxt = ctx_i.line + 1'b1;
        end else if (char_i == "<") begin
          st_nxt = ST_LT;
          keep   = 1'b1;
        end else if (char_i == "=") begin
          st_nxt = ST_EQ;
          keep   = 1'b1;
        end else if (char_i == ">") begin
          st_nxt = ST_GT;
          keep   = 1'b1;
        end else if (char_i == "!") begin
          st_nxt = ST_BANG;
          keep   = 1'b1;
        end else begin
          keep = 1'b1;
          emit = 1'b1;
          case (char_i)
            "+":     kind = K_PLUS;
            "-":     kind = K_MINUS;
            "*":     kind = K_TIMES;
            "(":     kind = K_LPAREN;
            ")":     kind = K_RPAREN;
            ";":     kind = K_SEMI;
            ":":     kind = K_COLON;
            ",":     kind = K_COMMA;
            "[":     kind = K_LBRACK;
            "]":     kind = K_RBRACK;
            "{":     kind = K_LBRACE;
            "}":     kind = K_RBRACE;
            default: kind = K_ERR;
          endcase
        end
      end
      ST_SLASH: begin
        if (!eof_i && char_i == "/") begin
          st_nxt = ST_LINECMT;
        end else if (!eof_i && char_i == "*") begin
          st_nxt = ST_BLOCK;
        end else begin
          emit  = 1'b1;
          kind  = K_DIV;
          again = 1'b1;
        end
      end
      ST_LINECMT: begin
        if (eof_i) begin
          emit = 1'b1;
          kind = K_EOF;
        end else if (char_i == CH_NL) begin
          st_nxt = ST_START;
          if (ctx_i.line != '1) line_nxt = ctx_i.line + 1'b1;
        end
      end
      ST_BLOCK: begin
        if (eof_i) begin
          emit = 1'b1;
          kind = K_EOF;
        end else if (char_i == "*") begin
          st_nxt = ST_STAR;
        end
      end
      ST_STAR: begin
        if (eof_i) begin
          emit = 1'b1;
          kind = K_EOF;
        end else if (char_i == "/") begin
          st_nxt = ST_START;
        end else if (char_i != "*") begin
          st_nxt = ST_BLOCK;
        end
      end
      ST_LT, ST_EQ, ST_GT, ST_BANG: begin
        emit = 1'b1;
        if (!eof_i && char_i == "=") begin
          keep = 1'b1;
          case (ctx_i.state)
            ST_LT:   kind = K_LE;
            ST_EQ:   kind = K_EQ;
            ST_GT:   kind = K_GE;
            default: kind = K_NE;
          endcase
        end else begin
          again = 1'b1;
          case (ctx_i.state)
            ST_LT:   kind = K_LT;
            ST_EQ:   kind = K_ASSIGN;
            ST_GT:   kind = K_GT;
            default: kind = K_NE;
          endcase
        end
      end
      ST_NUM: begin
        if (!eof_i && char_i == ".") begin
          st_nxt = ST_FRAC;
          keep   = 1'b1;
        end else if (!eof_i && is_digit) begin
          keep = 1'b1;
        end else begin
          emit  = 1'b1;
          kind  = K_NUM;
          again = 1'b1;
        end
      end
      ST_FRAC: begin
        if (!eof_i && is_digit) begin
          keep = 1'b1;
        end else begin
          emit  = 1'b1;
          kind  = K_NUM;
          again = 1'b1;
        end
      end
      ST_ID: begin
        if (!eof_i && (is_letter || is_digit)) begin
          keep = 1'b1;
        end else begin
          emit  = 1'b1;
          kind  = K_ID;
          again = 1'b1;
        end
      end
      default: begin
        emit = 1'b1;
        kind = K_ERR;
      end
    endcase
  end

  // Track kept characters and prune the reserved-word candidates
  always_comb begin
    len_nxt   = ctx_i.len;
    alive_nxt = ctx_i.alive;
    if (keep) begin
      if (ctx_i.len == '1) begin
        alive_nxt = '0;
      end else begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (ctx_i.len >= LEN_BITS'(KW_LEN[k]) ||
              KW_CH[k][ctx_i.len[2:0]] != char_i) begin
            alive_nxt[k] = 1'b0;
          end
        end
        len_nxt = ctx_i.len + 1'b1;
      end
    end
  end

  // Resolve identifiers against surviving reserved words, first match wins
  always_comb begin
    res_o.emit  = emit;
    res_o.again = again;
    res_o.kind  = kind;
    res_o.len   = len_nxt;
    found       = 1'b0;
    if (kind == K_ID) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (!found && alive_nxt[k] && len_nxt == LEN_BITS'(KW_LEN[k])) begin
          found      = 1'b1;
          res_o.kind = K_KW0 + 5'(k);
        end
      end
    end
  end

  // A completed token restarts the lexeme from empty
  always_comb begin
    ctx_o.line = line_nxt;
    if (emit) begin
      ctx_o.state = ST_START;
      ctx_o.len   = '0;
      ctx_o.alive = '1;
    end else begin
      ctx_o.state = st_nxt;
      ctx_o.len   = len_nxt;
      ctx_o.alive = alive_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_c_minus_token_scanner_top.sv @@
// Self-checking testbench for the C-minus token scanner: stimulus, token predictor, checker.
`timescale 1ns / 100ps

module tb_c_minus_token_scanner_top;
  import cmts_pkg::*;

  // One source character or end mark as queued for the driver
  typedef struct packed {
    logic       eof;
    logic [7:0] code;
  } src_char_t;

  localparam int HOLD_CYCLES    = 200;   // long sink hold-off for the back-pressure test
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles with work outstanding
  localparam int DRAIN_CYCLES   = 20;    // wait for stray tokens after the last expected one
  localparam int MAX_REPORTS    = 40;

  // Clock and the single reset pulse at the start of the run
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // Local copies of every block input, known from time zero
  logic       drv_valid  = 1'b0;
  logic [7:0] drv_char   = 8'h00;
  logic       drv_eof    = 1'b0;
  logic       sink_ready = 1'b0;

  cmts_in_if  in_chan ();
  cmts_out_if out_chan ();

  assign in_chan.valid        = drv_valid;
  assign in_chan.char_code    = drv_char;
  assign in_chan.end_of_input = drv_eof;
  assign out_chan.ready       = sink_ready;

  c_minus_token_scanner_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Stimulus and expectation stores
  src_char_t pending_chars [$];
  token_t    expected_tokens [$];
  src_char_t next_char;

  // Handshake shaping, set by the sequencer between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_start     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Run statistics
  int          char_transfers  = 0;
  int          eof_transfers   = 0;
  int          token_transfers = 0;
  int          mismatches      = 0;
  logic [31:0] kinds_seen      = '0;

  // Predictor state: mirrors the scanner's automaton
  scan_state_t           sc_state = ST_START;
  logic [LINE_BITS-1:0]  sc_line  = '0;
  logic [LEN_BITS-1:0]   sc_len   = '0;
  logic [KW_COUNT-1:0]   sc_alive = '1;

  // ---------------------------------------------------------------------------
  // Reserved-word spelling, in token-kind order starting at kind 2
  // ---------------------------------------------------------------------------
  function automatic int kw_size(input int k);
    case (k)
      0: kw_size = 3;
      1: kw_size = 6;
      2: kw_size = 4;
      3: kw_size = 2;
      4: kw_size = 4;
      5: kw_size = 5;
      6: kw_size = 3;
      default: kw_size = 6;
    endcase
  endfunction

  function automatic logic [47:0] kw_spelling(input int k);
    case (k)
      0: kw_spelling = "int";
      1: kw_spelling = "double";
      2: kw_spelling = "void";
      3: kw_spelling = "if";
      4: kw_spelling = "else";
      5: kw_spelling = "while";
      6: kw_spelling = "for";
      default: kw_spelling = "return";
    endcase
  endfunction

  // Character at position pos of reserved word k; the text is right-aligned
  function automatic logic [7:0] kw_byte(input int k, input int pos);
    logic [47:0] word;
    word = kw_spelling(k);
    if (pos >= kw_size(k)) kw_byte = 8'h00;
    else kw_byte = word[(kw_size(k) - 1 - pos) * 8 +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [4:0] single_symbol_kind(input logic [7:0] c);
    case (c)
      "+": single_symbol_kind = K_PLUS;
      "-": single_symbol_kind = K_MINUS;
      "*": single_symbol_kind = K_TIMES;
      "(": single_symbol_kind = K_LPAREN;
      ")": single_symbol_kind = K_RPAREN;
      ";": single_symbol_kind = K_SEMI;
      ":": single_symbol_kind = K_COLON;
      ",": single_symbol_kind = K_COMMA;
      "[": single_symbol_kind = K_LBRACK;
      "]": single_symbol_kind = K_RBRACK;
      "{": single_symbol_kind = K_LBRACE;
      "}": single_symbol_kind = K_RBRACE;
      default: single_symbol_kind = K_ERR;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  // Count a newline; the count sticks at its maximum
  task automatic bump_line();
    if (sc_line != '1) sc_line = sc_line + 1'b1;
  endtask

  // Add a character to the lexeme and narrow the set of reserved words still possible
  task automatic keep_char(input logic [7:0] c);
    if (sc_len == '1) begin
      sc_alive = '0;
    end else begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (sc_len >= kw_size(k) || kw_byte(k, sc_len) != c) sc_alive[k] = 1'b0;
      end
      sc_len = sc_len + 1'b1;
    end
  endtask

  // One automaton step; emit flags a completed token, again asks for a rescan of c
  task automatic scan_step(input logic [7:0] c, input logic eof,
                           output logic emit, output logic [4:0] kind, output logic again);
    logic keep;
    logic found;
    keep  = 1'b0;
    emit  = 1'b0;
    kind  = K_ERR;
    again = 1'b0;
    case (sc_state)
      ST_START: begin
        if (eof) begin
          emit = 1'b1; kind = K_EOF;
        end else if (is_digit(c)) begin
          sc_state = ST_NUM; keep = 1'b1;
        end else if (is_letter(c)) begin
          sc_state = ST_ID; keep = 1'b1;
        end else if (c == "/") begin
          sc_state = ST_SLASH;
        end else if (c == " " || c == "\t") begin
          // blanks are dropped
        end else if (c == "\n") begin
          bump_line();
        end else if (c == "<") begin
          sc_state = ST_LT; keep = 1'b1;
        end else if (c == "=") begin
          sc_state = ST_EQ; keep = 1'b1;
        end else if (c == ">") begin
          sc_state = ST_GT; keep = 1'b1;
        end else if (c == "!") begin
          sc_state = ST_BANG; keep = 1'b1;
        end else begin
          keep = 1'b1; emit = 1'b1; kind = single_symbol_kind(c);
        end
      end
      ST_SLASH: begin
        if (!eof && c == "/") sc_state = ST_LINECMT;
        else if (!eof && c == "*") sc_state = ST_BLOCK;
        else begin
          emit = 1'b1; kind = K_DIV; again = 1'b1;
        end
      end
      ST_LINECMT: begin
        if (eof) begin
          emit = 1'b1; kind = K_EOF;
        end else if (c == "\n") begin
          sc_state = ST_START; bump_line();
        end
      end
      ST_BLOCK: begin
        if (eof) begin
          emit = 1'b1; kind = K_EOF;
        end else if (c == "*") begin
          sc_state = ST_STAR;
        end
      end
      ST_STAR: begin
        if (eof) begin
          emit = 1'b1; kind = K_EOF;
        end else if (c == "/") begin
          sc_state = ST_START;
        end else if (c != "*") begin
          sc_state = ST_BLOCK;
        end
      end
      ST_LT, ST_EQ, ST_GT, ST_BANG: begin
        emit = 1'b1;
        if (!eof && c == "=") begin
          keep = 1'b1;
          case (sc_state)
            ST_LT:   kind = K_LE;
            ST_EQ:   kind = K_EQ;
            ST_GT:   kind = K_GE;
            default: kind = K_NE;
          endcase
        end else begin
          again = 1'b1;
          case (sc_state)
            ST_LT:   kind = K_LT;
            ST_EQ:   kind = K_ASSIGN;
            ST_GT:   kind = K_GT;
            default: kind = K_NE;
          endcase
        end
      end
      ST_NUM: begin
        if (!eof && c == ".") begin
          sc_state = ST_FRAC; keep = 1'b1;
        end else if (!eof && is_digit(c)) begin
          keep = 1'b1;
        end else begin
          emit = 1'b1; kind = K_NUM; again = 1'b1;
        end
      end
      ST_FRAC: begin
        if (!eof && is_digit(c)) keep = 1'b1;
        else begin
          emit = 1'b1; kind = K_NUM; again = 1'b1;
        end
      end
      ST_ID: begin
        if (!eof && (is_letter(c) || is_digit(c))) keep = 1'b1;
        else begin
          emit = 1'b1; kind = K_ID; again = 1'b1;
        end
      end
      default: begin
        emit = 1'b1; kind = K_ERR;
      end
    endcase
    if (keep) keep_char(c);
    // Promote an identifier to a reserved word when one survived to full length
    if (emit && kind == K_ID) begin
      found = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (!found && sc_alive[k] && sc_len == kw_size(k)) begin
          kind  = K_KW0 + k[4:0];
          found = 1'b1;
        end
      end
    end
  endtask

  // Work out the tokens caused by one transferred character and queue them
  task automatic predict_tokens(input logic [7:0] c, input logic eof);
    token_t     run [2];
    int         count;
    logic       go;
    logic       emit;
    logic       again;
    logic [4:0] kind;
    count = 0;
    go    = 1'b1;
    for (int pass = 0; pass < 2 && go; pass++) begin
      scan_step(c, eof, emit, kind, again);
      if (!emit) begin
        go = 1'b0;
      end else begin
        run[count].kind = kind;
        run[count].line = sc_line;
        run[count].len  = sc_len;
        run[count].last = 1'b1;
        if (count > 0) run[count - 1].last = 1'b0;
        count++;
        sc_state = ST_START;
        sc_len   = '0;
        sc_alive = '1;
        go       = again;
      end
    end
    for (int i = 0; i < count; i++) expected_tokens.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at token %0d: %s got %0d, expected %0d",
               token_transfers, what, got, want);
  endtask

  task automatic check_token();
    token_t want;
    token_transfers++;
    kinds_seen[out_chan.token_kind] = 1'b1;
    if (expected_tokens.size() == 0) begin
      report_mismatch("token with none expected, kind", out_chan.token_kind, 0);
    end else begin
      want = expected_tokens.pop_front();
      if (out_chan.token_kind !== want.kind)
        report_mismatch("token_kind", out_chan.token_kind, want.kind);
      if (out_chan.line_number !== want.line)
        report_mismatch("line_number", out_chan.line_number, want.line);
      if (out_chan.lexeme_length !== want.len)
        report_mismatch("lexeme_length", out_chan.lexeme_length, want.len);
      if (out_chan.last_of_run !== want.last)
        report_mismatch("last_of_run", out_chan.last_of_run, want.last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next pending character, hold it until its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_chan.ready) begin
        char_transfers++;
        if (drv_eof) eof_transfers++;
        predict_tokens(drv_char, drv_eof);
      end
      // Advance only when the slot is free or has just been taken
      if (!drv_valid || in_chan.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = pending_chars.pop_front();
          drv_valid <= 1'b1;
          drv_char  <= next_char.code;
          drv_eof   <= next_char.eof;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each token transfer, stall the sink at random or on hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_chan.valid && sink_ready) check_token();
      sink_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long sink hold-off, started whenever the sequencer bumps hold_start
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_start != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_start;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: count cycles without a transfer while work is still outstanding
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((drv_valid && in_chan.ready) || (out_chan.valid && sink_ready) ||
                 (!drv_valid && pending_chars.size() == 0 && expected_tokens.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
               quiet_cycles, expected_tokens.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    src_char_t item;
    item.eof  = 1'b0;
    item.code = b;
    pending_chars.push_back(item);
  endtask

  // End mark with a random byte beside it, which the scanner must ignore
  task automatic push_eof();
    src_char_t item;
    item.eof  = 1'b1;
    item.code = 8'($urandom_range(255));
    pending_chars.push_back(item);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_keyword(input int k, input int upto);
    for (int p = 0; p < upto; p++) push_byte(kw_byte(k, p));
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) rand_letter = 8'("a" + r);
    else if (r < 52) rand_letter = 8'("A" + r - 26);
    else rand_letter = "_";
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(9) < 3) rand_alnum = 8'("0" + $urandom_range(9));
    else rand_alnum = rand_letter();
  endfunction

  function automatic logic [7:0] rand_symbol();
    string set;
    set = "+-*()[]{};:,<>=!/";
    rand_symbol = set[$urandom_range(set.len() - 1)];
  endfunction

  // One well-formed lexeme, comment or blank, with a share of noise and broken forms
  task automatic queue_lexeme();
    int k;
    case ($urandom_range(19))
      0, 1: begin
        k = $urandom_range(KW_COUNT - 1);
        push_keyword(k, kw_size(k));
      end
      2: begin
        // near-miss of a reserved word: a prefix, or the word with a tail
        k = $urandom_range(KW_COUNT - 1);
        if ($urandom_range(1)) begin
          push_keyword(k, $urandom_range(1, kw_size(k) - 1));
        end else begin
          push_keyword(k, kw_size(k));
          push_byte(rand_alnum());
        end
      end
      3, 4: begin
        push_byte(rand_letter());
        repeat ($urandom_range(7)) push_byte(rand_alnum());
      end
      5, 6: begin
        repeat ($urandom_range(1, 4)) push_byte(8'("0" + $urandom_range(9)));
        if ($urandom_range(1)) begin
          push_byte(".");
          repeat ($urandom_range(3)) push_byte(8'("0" + $urandom_range(9)));
        end
      end
      7, 8: push_byte(rand_symbol());
      9: begin
        case ($urandom_range(3))
          0: push_text("<=");
          1: push_text(">=");
          2: push_text("==");
          default: push_text("!=");
        endcase
      end
      10, 11, 12: begin
        case ($urandom_range(2))
          0: push_byte(" ");
          1: push_byte("\t");
          default: push_byte("\n");
        endcase
      end
      13: begin
        push_text("//");
        repeat ($urandom_range(8)) push_byte(8'($urandom_range(32, 126)));
        push_byte("\n");
      end
      14: begin
        push_text("/*");
        repeat ($urandom_range(10)) begin
          case ($urandom_range(5))
            0, 1:    push_byte("*");
            2:       push_byte("\n");
            default: push_byte(8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(1)) push_text("*/");
        else push_text("**/");
      end
      15: push_byte(8'($urandom_range(255)));
      16: begin
        if ($urandom_range(2) == 0) push_eof();
        else push_byte(" ");
      end
      17: begin
        push_byte("/");
        push_byte(8'($urandom_range(255)));
      end
      18: begin
        push_byte("!");
        push_byte(8'($urandom_range(32, 126)));
      end
      default: begin
        if ($urandom_range(1)) push_byte(8'h0D);
        else push_byte(".");
      end
    endcase
  endtask

  task automatic queue_random(input int count);
    int target;
    target = pending_chars.size() + count;
    while (pending_chars.size() < target) queue_lexeme();
  endtask

  // Hold the sequencer until every queued character has been transferred
  task automatic drain_pending();
    while (pending_chars.size() != 0 || drv_valid) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: keyword, brackets, not-equal, fraction, block comment with
    // stray and doubled stars, lone bang, division sign before a carriage return,
    // a high byte, a line comment, end mark inside a token, then a repeated end mark
    push_text("if(ab!=7.5)");
    push_text("/*c*x**/");
    push_text("!q/");
    push_byte(8'h0D);
    push_byte(8'hFF);
    push_text("//z\n");
    push_text("x");
    push_eof();
    push_eof();

    // No idling; hold the sink off for a long stretch so the scanner fills and
    // stalls its input while the driver keeps offering characters
    hold_start++;
    queue_random(200);
    drain_pending();

    // Sender gaps
    send_idle_pct = 49;
    queue_random(200);
    drain_pending();

    // Sink stalls
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    queue_random(200);
    drain_pending();

    // Both sides idle now and then
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    queue_random(200);
    drain_pending();

    // Saturation at full rate: a reserved-word prefix run on past the longest
    // lexeme length, so the count pins and no reserved word survives
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_keyword(7, 6);
    repeat (254) push_byte("n");
    push_byte(" ");
    push_text("x1=y;");
    drain_pending();

    send_idle_pct  = 24;
    recv_stall_pct = 24;
    queue_random(100);
    push_eof();
    drain_pending();

    // Drop to idle, wait for the last tokens, then allow stray ones to show up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch("tokens left over, count", 0, expected_tokens.size());

    $display("Scanned %0d characters (%0d end marks), checked %0d tokens, %0d kinds.",
             char_transfers, eof_transfers, token_transfers, $countones(kinds_seen));
    $display("Phases: idle, stalls, long hold-off, length saturation; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
